### src/caflu_pkg.sv
// Shared types, widths and sequencer step codes for the limited flux update core.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package caflu_pkg;

  localparam int WORD_W  = 32;
  localparam int DIFF_W  = 33;
  localparam int SLOPE_W = 36;
  localparam int FACE_W  = 34;
  localparam int MUL_W   = 34;
  localparam int PROD_W  = 68;
  localparam int WIDE_W  = 69;
  localparam int STEP_W  = 5;
  localparam int INDEX_W = 17;
  localparam int THETA_W = 18;
  localparam int DTDX_W  = 17;
  localparam int GHOST_W = 4;
  localparam int COUNT_W = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [THETA_W-1:0] THETA_MAX = 18'd131072;
  localparam logic [INDEX_W-1:0] INDEX_MAX = 17'h1FFFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THETA   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DTDX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GHOST   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 3'd5;

  // sequencer steps; a product issued in one step is consumed in the next
  localparam logic [STEP_W-1:0] S_DIFF     = 5'd0;
  localparam logic [STEP_W-1:0] S_TH_U1    = 5'd1;
  localparam logic [STEP_W-1:0] S_TH_U2    = 5'd2;
  localparam logic [STEP_W-1:0] S_TH_U3    = 5'd3;
  localparam logic [STEP_W-1:0] S_TH_V1    = 5'd4;
  localparam logic [STEP_W-1:0] S_TH_V2    = 5'd5;
  localparam logic [STEP_W-1:0] S_TH_V3    = 5'd6;
  localparam logic [STEP_W-1:0] S_TH_END   = 5'd7;
  localparam logic [STEP_W-1:0] S_SLOPE    = 5'd8;
  localparam logic [STEP_W-1:0] S_FACE     = 5'd9;
  localparam logic [STEP_W-1:0] S_SPD_BUR  = 5'd10;
  localparam logic [STEP_W-1:0] S_SPD_AVR  = 5'd11;
  localparam logic [STEP_W-1:0] S_SPD_BUL  = 5'd12;
  localparam logic [STEP_W-1:0] S_SPD_AVL  = 5'd13;
  localparam logic [STEP_W-1:0] S_PROD     = 5'd14;
  localparam logic [STEP_W-1:0] S_PROD_END = 5'd15;
  localparam logic [STEP_W-1:0] S_FA_LO    = 5'd16;
  localparam logic [STEP_W-1:0] S_FA_HI    = 5'd17;
  localparam logic [STEP_W-1:0] S_FB_LO    = 5'd18;
  localparam logic [STEP_W-1:0] S_FB_HI    = 5'd19;
  localparam logic [STEP_W-1:0] S_UPD_U    = 5'd20;
  localparam logic [STEP_W-1:0] S_UPD_V    = 5'd21;
  localparam logic [STEP_W-1:0] S_UPD_END  = 5'd22;
  localparam logic [STEP_W-1:0] S_FINISH   = 5'd23;

  typedef struct packed {
    logic              load;       // input transfer this cycle
    logic              shift_now;  // cell outside the update range: shift only
    logic              step_en;
    logic [STEP_W-1:0] step;
    logic              finish;     // shift window, keep flux, load result
    logic              emit;
    logic              last;
  } caflu_cmd_t;

endpackage

### src/coupled_advection_limited_flux_update_core.sv
// Top level of the limited flux update core: configuration registers, sequencer, datapath.
// Depends on caflu_pkg, caflu_ctrl and caflu_dp.
//
//   port group   direction  handshake            payload
//   cell in      in         in_valid / in_stall  u_sample, v_sample, frame_start
//   cell out     out        out_valid/out_stall  new_u, new_v, last_cell
//   config       in         cfg_write            cfg_index, cfg_data
//
// A cell inside the update range is taken in its transfer cycle and then runs 24 sequencer
// steps, set by the single shared 34x34 multiplier that carries 17 products per cell.
// Cells outside the range shift into the window in the transfer cycle itself.
// Synchronous reset restores register defaults, clears window, flux history and index.
// A finished result waits in the output register; a new cell is taken meanwhile, and the
// sequencer holds at its last step only while the previous result is still stalled.
`timescale 1ns / 1ps
module coupled_advection_limited_flux_update_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [caflu_pkg::WORD_W-1:0]    u_sample,
  input  logic signed [caflu_pkg::WORD_W-1:0]    v_sample,
  input  logic                                   frame_start,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [caflu_pkg::WORD_W-1:0]    new_u,
  output logic signed [caflu_pkg::WORD_W-1:0]    new_v,
  output logic                                   last_cell,
  input  logic                                   cfg_write,
  input  logic        [caflu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [caflu_pkg::WORD_W-1:0]    cfg_data
);
  import caflu_pkg::*;

  logic signed [WORD_W-1:0] coeff_a, coeff_b;
  logic [THETA_W-1:0]       limiter_theta;
  logic [DTDX_W-1:0]        dt_over_dx;
  logic [GHOST_W-1:0]       ghost_cells;
  logic [COUNT_W-1:0]       cell_count;
  caflu_cmd_t               cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_a       <= 32'sd65536;
      coeff_b       <= 32'sd65536;
      limiter_theta <= 18'd78643;
      dt_over_dx    <= 17'd32768;
      ghost_cells   <= 4'd3;
      cell_count    <= 16'd1000;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_COEFF_A: coeff_a       <= cfg_data;
        CFG_COEFF_B: coeff_b       <= cfg_data;
        CFG_THETA:   limiter_theta <= cfg_data[THETA_W-1:0];
        CFG_DTDX:    dt_over_dx    <= cfg_data[DTDX_W-1:0];
        CFG_GHOST:   ghost_cells   <= cfg_data[GHOST_W-1:0];
        CFG_COUNT:   cell_count    <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  caflu_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ghost_cells (ghost_cells),
    .cell_count  (cell_count),
    .cmd         (cmd)
  );

  caflu_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .u_sample      (u_sample),
    .v_sample      (v_sample),
    .frame_start   (frame_start),
    .coeff_a       (coeff_a),
    .coeff_b       (coeff_b),
    .limiter_theta (limiter_theta),
    .dt_over_dx    (dt_over_dx),
    .new_u         (new_u),
    .new_v         (new_v),
    .last_cell     (last_cell)
  );

endmodule

### src/caflu_ctrl.sv
// Sequencer for the flux update core: cell index, range decode, step counter, result valid.
// Depends on caflu_pkg.
`timescale 1ns / 1ps
module caflu_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          frame_start,
  output logic                          out_valid,
  input  logic                          out_stall,
  input  logic [caflu_pkg::GHOST_W-1:0] ghost_cells,
  input  logic [caflu_pkg::COUNT_W-1:0] cell_count,
  output caflu_pkg::caflu_cmd_t         cmd
);
  import caflu_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic               state;
  logic [STEP_W-1:0]  step;
  logic [INDEX_W-1:0] cell_index;
  logic               emit_q;
  logic               last_q;

  logic               accept;
  logic [INDEX_W-1:0] k;
  logic [INDEX_W:0]   k_ext;
  logic [INDEX_W:0]   lo_bound;
  logic [INDEX_W:0]   emit_bound;
  logic [INDEX_W:0]   hi_bound;
  logic               active;
  logic               emit_now;
  logic               out_free;
  logic               fin;
  logic               out_valid_next;

  assign in_stall   = (state != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign k          = frame_start ? '0 : cell_index;
  assign k_ext      = {1'b0, k};
  assign lo_bound   = (INDEX_W+1)'(ghost_cells) + (INDEX_W+1)'(1);
  assign emit_bound = (INDEX_W+1)'(ghost_cells) + (INDEX_W+1)'(2);
  assign hi_bound   = (INDEX_W+1)'(ghost_cells) + (INDEX_W+1)'(cell_count)
                      + (INDEX_W+1)'(1);
  assign active     = (k_ext >= lo_bound) && (k_ext <= hi_bound);
  assign emit_now   = (k_ext >= emit_bound);
  assign out_free   = !out_valid || !out_stall;
  assign fin        = (state == ST_RUN) && (step == S_FINISH) && (!emit_q || out_free);

  always_comb begin
    cmd.load      = accept;
    cmd.shift_now = accept && !active;
    cmd.step_en   = (state == ST_RUN);
    cmd.step      = step;
    cmd.finish    = fin;
    cmd.emit      = emit_q;
    cmd.last      = last_q;
  end

  // drop the result on its transfer, raise it when an emitting cell finishes
  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && !out_stall) out_valid_next = 1'b0;
    if (fin && emit_q) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= S_DIFF;
      cell_index <= '0;
      emit_q     <= 1'b0;
      last_q     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cell_index <= (k == INDEX_MAX) ? k : k + INDEX_W'(1);
            emit_q     <= emit_now;
            last_q     <= (k_ext == hi_bound);
            if (active) begin
              state <= ST_RUN;
              step  <= S_DIFF;
            end
          end
        end
        ST_RUN: begin
          if (step != S_FINISH) begin
            step <= step + STEP_W'(1);
          end else if (fin) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_start: assert property (@(posedge clk) disable iff (rst)
    (accept && active) |=> (state == ST_RUN && step == S_DIFF))
    else $error("sequence did not start on an in-range transfer");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (step <= S_FINISH))
    else $error("step counter past finish");
  a_no_early_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && step != S_FINISH) |=> (state == ST_RUN))
    else $error("sequence left before finish");
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(fin && emit_q))
    else $error("result valid without a finished emitting cell");

endmodule

### src/caflu_dp.sv
// Datapath: sample window, shared 34x34 multiplier, limiter, faces, flux and update.
// Depends on caflu_pkg; driven step by step from caflu_ctrl.
`timescale 1ns / 1ps
module caflu_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  caflu_pkg::caflu_cmd_t                cmd,
  input  logic signed [caflu_pkg::WORD_W-1:0]  u_sample,
  input  logic signed [caflu_pkg::WORD_W-1:0]  v_sample,
  input  logic                                 frame_start,
  input  logic signed [caflu_pkg::WORD_W-1:0]  coeff_a,
  input  logic signed [caflu_pkg::WORD_W-1:0]  coeff_b,
  input  logic        [caflu_pkg::THETA_W-1:0] limiter_theta,
  input  logic        [caflu_pkg::DTDX_W-1:0]  dt_over_dx,
  output logic signed [caflu_pkg::WORD_W-1:0]  new_u,
  output logic signed [caflu_pkg::WORD_W-1:0]  new_v,
  output logic                                 last_cell
);
  import caflu_pkg::*;

  localparam logic signed [WIDE_W-1:0] SAT_HI = 69'sd2147483647;
  localparam logic signed [WIDE_W-1:0] SAT_LO = -69'sd2147483648;

  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
    logic signed [WORD_W-1:0] r;
    if (x > SAT_HI)      r = 32'sh7FFFFFFF;
    else if (x < SAT_LO) r = 32'sh80000000;
    else                 r = x[WORD_W-1:0];
    return r;
  endfunction

  function automatic logic signed [DIFF_W-1:0] sub33(input logic signed [WORD_W-1:0] x,
                                                     input logic signed [WORD_W-1:0] y);
    return {x[WORD_W-1], x} - {y[WORD_W-1], y};
  endfunction

  function automatic logic [DIFF_W-1:0] mag33(input logic signed [DIFF_W-1:0] d);
    return d[DIFF_W-1] ? -d : d;
  endfunction

  // theta * |d| >> 15, sign restored (truncates toward zero)
  function automatic logic signed [SLOPE_W-1:0] tscale(input logic signed [PROD_W-1:0] p,
                                                       input logic neg);
    logic [SLOPE_W-1:0] q;
    q = {1'b0, p[49:15]};
    return neg ? -q : q;
  endfunction

  function automatic logic signed [SLOPE_W-1:0] minmod(input logic signed [SLOPE_W-1:0] x,
                                                       input logic signed [SLOPE_W-1:0] y,
                                                       input logic signed [SLOPE_W-1:0] z);
    logic signed [SLOPE_W-1:0] r;
    r = '0;
    if (x > 0 && y > 0 && z > 0) begin
      r = (x < y) ? x : y;
      r = (r < z) ? r : z;
    end else if (x < 0 && y < 0 && z < 0) begin
      r = (x > y) ? x : y;
      r = (r > z) ? r : z;
    end
    return r;
  endfunction

  // floor((4*w +/- s) / 4)
  function automatic logic signed [FACE_W-1:0] face(input logic signed [WORD_W-1:0] w,
                                                    input logic signed [SLOPE_W-1:0] s,
                                                    input logic sub);
    logic signed [SLOPE_W:0] acc;
    if (sub) acc = {{3{w[WORD_W-1]}}, w, 2'b00} - {s[SLOPE_W-1], s};
    else     acc = {{3{w[WORD_W-1]}}, w, 2'b00} + {s[SLOPE_W-1], s};
    return acc[FACE_W+1:2];
  endfunction

  function automatic logic pos_sum(input logic signed [PROD_W-1:0] x,
                                   input logic signed [PROD_W-1:0] y);
    logic signed [WIDE_W-1:0] s;
    s = {x[PROD_W-1], x} + {y[PROD_W-1], y};
    return s > 0;
  endfunction

  // hi part times 2^32 plus low partial product, floor shift by 32, saturate
  function automatic logic signed [WORD_W-1:0] flux(input logic signed [PROD_W-1:0] hi,
                                                    input logic signed [PROD_W-1:0] lo);
    logic signed [WIDE_W-1:0] s;
    s = {hi[PROD_W-1], hi} + {{33{lo[PROD_W-1]}}, lo[PROD_W-1:32]};
    return sat32(s);
  endfunction

  function automatic logic signed [WORD_W-1:0] update(input logic signed [WORD_W-1:0] w,
                                                      input logic signed [PROD_W-1:0] p);
    logic signed [WIDE_W-1:0] s;
    s = {{37{w[WORD_W-1]}}, w} - {{17{p[PROD_W-1]}}, p[PROD_W-1:16]};
    return sat32(s);
  endfunction

  logic signed [WORD_W-1:0]  u_w0, u_w1, u_w2, v_w0, v_w1, v_w2;
  logic signed [WORD_W-1:0]  u_cur, v_cur;
  logic signed [WORD_W-1:0]  prior_u, prior_v;
  logic [DIFF_W-1:0]         mu1, mu2, mu3, mv1, mv2, mv3;
  logic                      su1, su2, su3, sv1, sv2, sv3;
  logic signed [DIFF_W-1:0]  yru, ylu, yrv, ylv;
  logic signed [SLOPE_W-1:0] tu1, tu2, tu3, tv1, tv2, tv3;
  logic signed [SLOPE_W-1:0] sru, slu, srv, slv;
  logic signed [FACE_W-1:0]  ur, ul, vr, vl;
  logic signed [PROD_W-1:0]  prod, part;
  logic                      pos_r, pos;
  logic [63:0]               pw;
  logic signed [WORD_W-1:0]  fu, fv, nu, nv;

  logic signed [MUL_W-1:0]   ma, mb;
  logic [THETA_W-1:0]        th_c;
  logic signed [MUL_W-1:0]   th_op, r_op, plo_op, phi_op;
  logic signed [DIFF_W-1:0]  dfu, dfv;

  assign th_c   = (limiter_theta > THETA_MAX) ? THETA_MAX : limiter_theta;
  assign th_op  = {16'b0, th_c};
  assign r_op   = {17'b0, dt_over_dx};
  assign plo_op = {2'b00, pw[31:0]};
  assign phi_op = {{2{pw[63]}}, pw[63:32]};
  assign dfu    = sub33(fu, prior_u);
  assign dfv    = sub33(fv, prior_v);

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.step)
      S_TH_U1:   begin ma = {1'b0, mu1}; mb = th_op; end
      S_TH_U2:   begin ma = {1'b0, mu2}; mb = th_op; end
      S_TH_U3:   begin ma = {1'b0, mu3}; mb = th_op; end
      S_TH_V1:   begin ma = {1'b0, mv1}; mb = th_op; end
      S_TH_V2:   begin ma = {1'b0, mv2}; mb = th_op; end
      S_TH_V3:   begin ma = {1'b0, mv3}; mb = th_op; end
      S_SPD_BUR: begin ma = {{2{coeff_b[WORD_W-1]}}, coeff_b}; mb = ur; end
      S_SPD_AVR: begin ma = {{2{coeff_a[WORD_W-1]}}, coeff_a}; mb = vr; end
      S_SPD_BUL: begin ma = {{2{coeff_b[WORD_W-1]}}, coeff_b}; mb = ul; end
      S_SPD_AVL: begin ma = {{2{coeff_a[WORD_W-1]}}, coeff_a}; mb = vl; end
      S_PROD:    begin ma = ur; mb = vr; end
      S_FA_LO:   begin ma = {{2{coeff_a[WORD_W-1]}}, coeff_a}; mb = plo_op; end
      S_FA_HI:   begin ma = {{2{coeff_a[WORD_W-1]}}, coeff_a}; mb = phi_op; end
      S_FB_LO:   begin ma = {{2{coeff_b[WORD_W-1]}}, coeff_b}; mb = plo_op; end
      S_FB_HI:   begin ma = {{2{coeff_b[WORD_W-1]}}, coeff_b}; mb = phi_op; end
      S_UPD_U:   begin ma = r_op; mb = {dfu[DIFF_W-1], dfu}; end
      S_UPD_V:   begin ma = r_op; mb = {dfv[DIFF_W-1], dfv}; end
      default:   begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  // window and flux history
  always_ff @(posedge clk) begin
    if (rst) begin
      u_w0 <= '0; u_w1 <= '0; u_w2 <= '0;
      v_w0 <= '0; v_w1 <= '0; v_w2 <= '0;
      prior_u <= '0;
      prior_v <= '0;
    end else if (cmd.load) begin
      if (cmd.shift_now) begin
        u_w0 <= frame_start ? '0 : u_w1;
        u_w1 <= frame_start ? '0 : u_w2;
        u_w2 <= u_sample;
        v_w0 <= frame_start ? '0 : v_w1;
        v_w1 <= frame_start ? '0 : v_w2;
        v_w2 <= v_sample;
      end else if (frame_start) begin
        u_w0 <= '0; u_w1 <= '0; u_w2 <= '0;
        v_w0 <= '0; v_w1 <= '0; v_w2 <= '0;
      end
    end else if (cmd.finish) begin
      u_w0 <= u_w1; u_w1 <= u_w2; u_w2 <= u_cur;
      v_w0 <= v_w1; v_w1 <= v_w2; v_w2 <= v_cur;
      prior_u <= fu;
      prior_v <= fv;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      u_cur <= u_sample;
      v_cur <= v_sample;
    end
    if (cmd.finish && cmd.emit) begin
      new_u     <= nu;
      new_v     <= nv;
      last_cell <= cmd.last;
    end
    if (cmd.step_en) begin
      case (cmd.step)
        S_DIFF: begin
          mu1 <= mag33(sub33(u_w1, u_w0));  su1 <= u_w1 < u_w0;
          mu2 <= mag33(sub33(u_w2, u_w1));  su2 <= u_w2 < u_w1;
          mu3 <= mag33(sub33(u_cur, u_w2)); su3 <= u_cur < u_w2;
          mv1 <= mag33(sub33(v_w1, v_w0));  sv1 <= v_w1 < v_w0;
          mv2 <= mag33(sub33(v_w2, v_w1));  sv2 <= v_w2 < v_w1;
          mv3 <= mag33(sub33(v_cur, v_w2)); sv3 <= v_cur < v_w2;
          yru <= sub33(u_w2, u_w0);
          ylu <= sub33(u_cur, u_w1);
          yrv <= sub33(v_w2, v_w0);
          ylv <= sub33(v_cur, v_w1);
        end
        S_TH_U2:  tu1 <= tscale(prod, su1);
        S_TH_U3:  tu2 <= tscale(prod, su2);
        S_TH_V1:  tu3 <= tscale(prod, su3);
        S_TH_V2:  tv1 <= tscale(prod, sv1);
        S_TH_V3:  tv2 <= tscale(prod, sv2);
        S_TH_END: tv3 <= tscale(prod, sv3);
        S_SLOPE: begin
          sru <= minmod(tu1, {{3{yru[DIFF_W-1]}}, yru}, tu2);
          slu <= minmod(tu2, {{3{ylu[DIFF_W-1]}}, ylu}, tu3);
          srv <= minmod(tv1, {{3{yrv[DIFF_W-1]}}, yrv}, tv2);
          slv <= minmod(tv2, {{3{ylv[DIFF_W-1]}}, ylv}, tv3);
        end
        S_FACE: begin
          ur <= face(u_w1, sru, 1'b0);
          vr <= face(v_w1, srv, 1'b0);
          ul <= face(u_w2, slu, 1'b1);
          vl <= face(v_w2, slv, 1'b1);
        end
        S_SPD_AVR:  part  <= prod;
        S_SPD_BUL:  pos_r <= pos_sum(part, prod);
        S_SPD_AVL:  part  <= prod;
        S_PROD:     pos   <= pos_r | pos_sum(part, prod);
        S_PROD_END: pw    <= prod[63:0];
        S_FA_HI:    part  <= prod;
        S_FB_LO:    fu    <= pos ? flux(prod, part) : '0;
        S_FB_HI:    part  <= prod;
        S_UPD_U:    fv    <= pos ? flux(prod, part) : '0;
        S_UPD_V:    nu    <= update(u_w1, prod);
        S_UPD_END:  nv    <= update(v_w1, prod);
        default: ;
      endcase
    end
  end

endmodule
